### hdl/pwc_pkg.sv
// ============================================================================
// pwc_pkg
// Shared types and constants of the pixel window clipper: field widths,
// register indexes, reset values, screen size, item modes and the clip window record.
// ============================================================================
`default_nettype none

package pwc_pkg;

    // Field widths.
    localparam int C_REG_W   = 16;
    localparam int C_IDX_W   = 3;
    localparam int C_COLOR_W = 16;
    localparam int C_COL_W   = 16;
    localparam int C_ROW_W   = 17;

    // Screen size that a canvas bound inside the draw area is clamped to.
    localparam logic signed [C_REG_W-1:0] C_SCREEN_WIDTH  = 16'sd480;
    localparam logic signed [C_REG_W-1:0] C_SCREEN_HEIGHT = 16'sd320;

    // Reset values of the draw area.
    localparam logic signed [C_REG_W-1:0] C_AREA_RIGHT_RST  = 16'sd480;
    localparam logic signed [C_REG_W-1:0] C_AREA_BOTTOM_RST = 16'sd320;

    // Configuration register indexes.
    localparam logic [C_IDX_W-1:0] C_IDX_CORNER_A_X = 3'd0;
    localparam logic [C_IDX_W-1:0] C_IDX_CORNER_A_Y = 3'd1;
    localparam logic [C_IDX_W-1:0] C_IDX_CORNER_B_X = 3'd2;
    localparam logic [C_IDX_W-1:0] C_IDX_CORNER_B_Y = 3'd3;
    localparam logic [C_IDX_W-1:0] C_IDX_AREA_LEFT  = 3'd4;
    localparam logic [C_IDX_W-1:0] C_IDX_AREA_RIGHT = 3'd5;
    localparam logic [C_IDX_W-1:0] C_IDX_AREA_TOP   = 3'd6;
    localparam logic [C_IDX_W-1:0] C_IDX_AREA_BOT   = 3'd7;

    // Item modes.
    localparam logic C_MODE_PIXEL  = 1'b0;
    localparam logic C_MODE_REWIND = 1'b1;

    // Clip window, canvas origin and canvas width minus one, derived from the configuration.
    typedef struct packed {
        logic signed [C_REG_W-1:0] left;
        logic signed [C_REG_W-1:0] right;
        logic signed [C_REG_W-1:0] top;
        logic signed [C_REG_W-1:0] bottom;
        logic signed [C_REG_W-1:0] x1;
        logic signed [C_REG_W-1:0] y1;
        logic        [C_COL_W-1:0] width;
    } t_window;

endpackage

`default_nettype wire

### hdl/pwc_pix_if.sv
// ============================================================================
// pwc_pix_if
// Input channel of the clipper: a pixel or rewind item with its color.
// ============================================================================
`default_nettype none

interface pwc_pix_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] color;

    modport source (output valid, output mode, output color, input ready);
    modport sink   (input valid, input mode, input color, output ready);
endinterface

`default_nettype wire

### hdl/pwc_out_if.sv
// ============================================================================
// pwc_out_if
// Output channel of the clipper: the color of a pixel inside the window.
// ============================================================================
`default_nettype none

interface pwc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

### hdl/pwc_window.sv
// ============================================================================
// pwc_window
// Orders the two canvas corners and derives the clip window: each bound is
// the draw-area edge when the canvas passes it, else clamped to the screen.
// ============================================================================
`default_nettype none

module pwc_window import pwc_pkg::*; (
    input  wire logic signed [C_REG_W-1:0] i_corner_a_x,
    input  wire logic signed [C_REG_W-1:0] i_corner_a_y,
    input  wire logic signed [C_REG_W-1:0] i_corner_b_x,
    input  wire logic signed [C_REG_W-1:0] i_corner_b_y,
    input  wire logic signed [C_REG_W-1:0] i_area_left,
    input  wire logic signed [C_REG_W-1:0] i_area_right,
    input  wire logic signed [C_REG_W-1:0] i_area_top,
    input  wire logic signed [C_REG_W-1:0] i_area_bottom,
    output t_window                        o_window
);

    // Clamp a value into 0..hi.
    function automatic logic signed [C_REG_W-1:0] clamp_screen(
        input logic signed [C_REG_W-1:0] v,
        input logic signed [C_REG_W-1:0] hi
    );
        logic signed [C_REG_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic signed [C_REG_W-1:0] x1, x2, y1, y2;
    logic        [C_REG_W:0]   w_diff;

    // Order the corners.
    always_comb begin
        if (i_corner_a_x < i_corner_b_x) begin
            x1 = i_corner_a_x;
            x2 = i_corner_b_x;
        end else begin
            x1 = i_corner_b_x;
            x2 = i_corner_a_x;
        end
        if (i_corner_a_y < i_corner_b_y) begin
            y1 = i_corner_a_y;
            y2 = i_corner_b_y;
        end else begin
            y1 = i_corner_b_y;
            y2 = i_corner_a_y;
        end
    end

    // Canvas width minus one; never negative since x2 >= x1.
    assign w_diff = {x2[C_REG_W-1], x2} - {x1[C_REG_W-1], x1};

    // Window bounds.
    always_comb begin
        o_window.left   = (x1 < i_area_left)   ? i_area_left
                                               : clamp_screen(x1, C_SCREEN_WIDTH);
        o_window.right  = (x2 > i_area_right)  ? i_area_right
                                               : clamp_screen(x2, C_SCREEN_WIDTH);
        o_window.top    = (y1 < i_area_top)    ? i_area_top
                                               : clamp_screen(y1, C_SCREEN_HEIGHT);
        o_window.bottom = (y2 > i_area_bottom) ? i_area_bottom
                                               : clamp_screen(y2, C_SCREEN_HEIGHT);
        o_window.x1     = x1;
        o_window.y1     = y1;
        o_window.width  = w_diff[C_COL_W-1:0];
    end

endmodule

`default_nettype wire

### hdl/pixel_window_clipper_unit.sv
// ============================================================================
// pixel_window_clipper_unit
// Scissor clipper for a raster pixel stream. Pixel items walk a position
// through the canvas; colors inside the clip window are passed on.
// ============================================================================
//
//  Channel   Dir  Handshake        Payload
//  i_pix     in   valid/ready      mode, color
//  o_pix     out  valid/ready      pixel_color
//  i_cfg_*   in   write enable     index, 16-bit data
//
//  An item is taken into an input register, then judged and stepped through
//  the canvas into the output register. One item per cycle is sustained
//  while the output is not stalled; rewinds and clipped pixels leave no
//  result. A stall on the output holds only items that produce a result;
//  the input register keeps accepting while the output register can drain.
//  Synchronous reset clears the position and the valid flags and loads the
//  configuration registers with their reset values.
`default_nettype none

module pixel_window_clipper_unit import pwc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [C_IDX_W-1:0] i_cfg_index,
    input  wire logic [C_REG_W-1:0] i_cfg_data,
    pwc_pix_if.sink                 i_pix,
    pwc_out_if.source               o_pix
);

    // Configuration registers.
    logic signed [C_REG_W-1:0] r_corner_a_x, r_corner_a_y, r_corner_b_x, r_corner_b_y;
    logic signed [C_REG_W-1:0] r_area_left, r_area_right, r_area_top, r_area_bottom;

    // Canvas position.
    logic [C_COL_W-1:0] r_col, n_col;
    logic [C_ROW_W-1:0] r_row, n_row;

    // Input and output stages.
    logic                 r_s1_valid;
    logic                 r_s1_mode;
    logic [C_COLOR_W-1:0] r_s1_color;
    logic                 r_out_valid;
    logic [C_COLOR_W-1:0] r_out_color;

    t_window               window;
    logic signed [C_REG_W+1:0] px;
    logic signed [C_REG_W+2:0] py;
    logic                  in_window;
    logic                  s1_hit;
    logic                  s1_go;
    logic                  out_free;
    logic                  corner_wr;

    pwc_window u_window (
        .i_corner_a_x (r_corner_a_x),
        .i_corner_a_y (r_corner_a_y),
        .i_corner_b_x (r_corner_b_x),
        .i_corner_b_y (r_corner_b_y),
        .i_area_left  (r_area_left),
        .i_area_right (r_area_right),
        .i_area_top   (r_area_top),
        .i_area_bottom(r_area_bottom),
        .o_window     (window)
    );

    // Configuration writes; a corner write rewinds the position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_a_x  <= '0;
            r_corner_a_y  <= '0;
            r_corner_b_x  <= '0;
            r_corner_b_y  <= '0;
            r_area_left   <= '0;
            r_area_right  <= C_AREA_RIGHT_RST;
            r_area_top    <= '0;
            r_area_bottom <= C_AREA_BOTTOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_IDX_CORNER_A_X: r_corner_a_x  <= i_cfg_data;
                C_IDX_CORNER_A_Y: r_corner_a_y  <= i_cfg_data;
                C_IDX_CORNER_B_X: r_corner_b_x  <= i_cfg_data;
                C_IDX_CORNER_B_Y: r_corner_b_y  <= i_cfg_data;
                C_IDX_AREA_LEFT:  r_area_left   <= i_cfg_data;
                C_IDX_AREA_RIGHT: r_area_right  <= i_cfg_data;
                C_IDX_AREA_TOP:   r_area_top    <= i_cfg_data;
                C_IDX_AREA_BOT:   r_area_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign corner_wr = i_cfg_we && ((i_cfg_index == C_IDX_CORNER_A_X) ||
                                    (i_cfg_index == C_IDX_CORNER_A_Y) ||
                                    (i_cfg_index == C_IDX_CORNER_B_X) ||
                                    (i_cfg_index == C_IDX_CORNER_B_Y));

    // Pixel position on the screen and the window test, all signed.
    assign px = {{2{window.x1[C_REG_W-1]}}, window.x1} + $signed({2'b00, r_col});
    assign py = {{3{window.y1[C_REG_W-1]}}, window.y1} + $signed({2'b00, r_row});

    assign in_window = (px >= $signed({{2{window.left[C_REG_W-1]}}, window.left}))
                    && (px <= $signed({{2{window.right[C_REG_W-1]}}, window.right}))
                    && (py >= $signed({{3{window.top[C_REG_W-1]}}, window.top}))
                    && (py <= $signed({{3{window.bottom[C_REG_W-1]}}, window.bottom}));

    // Stage control: only a passed pixel needs room in the output register.
    assign s1_hit      = (r_s1_mode == C_MODE_PIXEL) && in_window;
    assign out_free    = !r_out_valid || o_pix.ready;
    assign s1_go       = r_s1_valid && (!s1_hit || out_free);
    assign i_pix.ready = !r_s1_valid || s1_go;

    // Next position: rewind, or raster step with a saturating row.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s1_go) begin
            if (r_s1_mode == C_MODE_REWIND) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col >= window.width) begin
                n_col = '0;
                if (r_row != {C_ROW_W{1'b1}}) begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (corner_wr) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_s1_mode  <= i_pix.mode;
            r_s1_color <= i_pix.color;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_hit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_hit) begin
            r_out_color <= r_s1_color;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_color = r_out_color;

endmodule

`default_nettype wire

### tb/pixel_clip_checker.sv
// ============================================================================
// pixel_clip_checker
// Watches the configuration port and both item channels of the pixel window
// clipper. It tracks the registers and the raster position, predicts which
// pixel colors leave the block, and compares every output item with the
// oldest predicted color.
// ============================================================================
`default_nettype none

module pixel_clip_checker import pwc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [C_IDX_W-1:0] i_cfg_index,
    input  wire logic [C_REG_W-1:0] i_cfg_data,
    pwc_pix_if                      i_pix,
    pwc_out_if                      i_out,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [C_REG_W-1:0]   clip_reg [8];
    logic        [C_COL_W-1:0]   column_pos;
    logic        [C_ROW_W-1:0]   row_pos;
    logic        [C_COLOR_W-1:0] expected_colors [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Clamps a canvas bound to the screen range 0..limit.
    function automatic int clamp_to_screen(input int value, input int limit);
        if (value < 0) return 0;
        if (value > limit) return limit;
        return value;
    endfunction

    // One pass per rising edge: reset, register writes, output items, then
    // input items. An input item cannot leave the block in the same cycle,
    // so outputs are matched before the new item is predicted.
    always @(posedge i_clk) begin : monitor
        int ax, ay, bx, by;
        int x1, x2, y1, y2;
        int lo_x, hi_x, lo_y, hi_y;
        int px, py;
        logic [C_COLOR_W-1:0] want;

        if (!i_rst_n) begin
            foreach (clip_reg[k]) clip_reg[k] = '0;
            clip_reg[C_IDX_AREA_RIGHT] = C_AREA_RIGHT_RST;
            clip_reg[C_IDX_AREA_BOT]   = C_AREA_BOTTOM_RST;
            column_pos = '0;
            row_pos    = '0;
            expected_colors.delete();
        end else begin
            // Any corner write puts the position back at the canvas start.
            if (i_cfg_we) begin
                clip_reg[i_cfg_index] = i_cfg_data;
                if (i_cfg_index <= C_IDX_CORNER_B_Y) begin
                    column_pos = '0;
                    row_pos    = '0;
                end
            end

            // Compare an accepted output item with the oldest prediction.
            if (i_out.valid && i_out.ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got pixel_color %h",
                             $time, i_out.pixel_color);
                    o_fail_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (i_out.pixel_color !== want) begin
                        $display("%0t: pixel_color mismatch, expected %h, got %h",
                                 $time, want, i_out.pixel_color);
                        o_fail_count++;
                    end
                end
            end

            // Predict the effect of an accepted input item.
            if (i_pix.valid && i_pix.ready) begin
                if (i_pix.mode == C_MODE_REWIND) begin
                    column_pos = '0;
                    row_pos    = '0;
                end else begin
                    ax = clip_reg[C_IDX_CORNER_A_X];
                    ay = clip_reg[C_IDX_CORNER_A_Y];
                    bx = clip_reg[C_IDX_CORNER_B_X];
                    by = clip_reg[C_IDX_CORNER_B_Y];
                    x1 = (ax < bx) ? ax : bx;
                    x2 = (ax < bx) ? bx : ax;
                    y1 = (ay < by) ? ay : by;
                    y2 = (ay < by) ? by : ay;

                    // Each bound takes the draw area when the canvas leaves
                    // it, otherwise the canvas bound clamped to the screen.
                    lo_x = (x1 < int'(clip_reg[C_IDX_AREA_LEFT])) ?
                           int'(clip_reg[C_IDX_AREA_LEFT]) :
                           clamp_to_screen(x1, int'(C_SCREEN_WIDTH));
                    hi_x = (x2 > int'(clip_reg[C_IDX_AREA_RIGHT])) ?
                           int'(clip_reg[C_IDX_AREA_RIGHT]) :
                           clamp_to_screen(x2, int'(C_SCREEN_WIDTH));
                    lo_y = (y1 < int'(clip_reg[C_IDX_AREA_TOP])) ?
                           int'(clip_reg[C_IDX_AREA_TOP]) :
                           clamp_to_screen(y1, int'(C_SCREEN_HEIGHT));
                    hi_y = (y2 > int'(clip_reg[C_IDX_AREA_BOT])) ?
                           int'(clip_reg[C_IDX_AREA_BOT]) :
                           clamp_to_screen(y2, int'(C_SCREEN_HEIGHT));

                    px = x1 + int'(column_pos);
                    py = y1 + int'(row_pos);
                    if (px >= lo_x && px <= hi_x && py >= lo_y && py <= hi_y)
                        expected_colors.push_back(i_pix.color);

                    // Raster step: wrap past the canvas width, row saturates.
                    if (int'(column_pos) >= x2 - x1) begin
                        column_pos = '0;
                        if (row_pos != '1) row_pos = row_pos + 1'b1;
                    end else begin
                        column_pos = column_pos + 1'b1;
                    end
                end
            end
        end
        o_pending = expected_colors.size();
    end

endmodule

`default_nettype wire

### tb/pixel_window_clipper_unit_test.sv
// ============================================================================
// pixel_window_clipper_unit_test
// Drives the pixel window clipper with directed corner cases, a back-pressure
// phase, and random configurations with random pixel streams. A checker
// beside the block predicts and compares every output item; this module
// gives the verdict.
// ============================================================================
`default_nettype none

module pixel_window_clipper_unit_test import pwc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [C_IDX_W-1:0] cfg_index;
    logic [C_REG_W-1:0] cfg_data;
    logic               hold_req;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    pwc_pix_if pix_ch ();
    pwc_out_if out_ch ();

    pixel_window_clipper_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_ch),
        .o_pix       (out_ch)
    );

    pixel_clip_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding", $time, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one item from a falling edge and returns at the falling edge
    // after it was accepted, with valid still high.
    task automatic send_item(input logic mode, input logic [C_COLOR_W-1:0] color);
        pix_ch.valid = 1'b1;
        pix_ch.mode  = mode;
        pix_ch.color = color;
        do @(posedge clk); while (!pix_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [C_COLOR_W-1:0] color);
        send_item(C_MODE_PIXEL, color);
    endtask

    // Stops offering, waits for every predicted item, then lets the
    // pipeline empty of items that leave no result.
    task automatic drain();
        pix_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [C_IDX_W-1:0] index, input logic [C_REG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic write_corners(input logic [C_REG_W-1:0] ax, input logic [C_REG_W-1:0] ay,
                                 input logic [C_REG_W-1:0] bx, input logic [C_REG_W-1:0] by);
        write_reg(C_IDX_CORNER_A_X, ax);
        write_reg(C_IDX_CORNER_A_Y, ay);
        write_reg(C_IDX_CORNER_B_X, bx);
        write_reg(C_IDX_CORNER_B_Y, by);
    endtask

    task automatic write_area(input logic [C_REG_W-1:0] lo_x, input logic [C_REG_W-1:0] hi_x,
                              input logic [C_REG_W-1:0] lo_y, input logic [C_REG_W-1:0] hi_y);
        write_reg(C_IDX_AREA_LEFT, lo_x);
        write_reg(C_IDX_AREA_RIGHT, hi_x);
        write_reg(C_IDX_AREA_TOP, lo_y);
        write_reg(C_IDX_AREA_BOT, hi_y);
    endtask

    // Mostly a small coordinate near the screen origin, sometimes an extreme.
    function automatic logic [C_REG_W-1:0] pick_coord(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom());
            default: return 16'(int'($urandom_range(0, hi - lo)) + lo);
        endcase
    endfunction

    // Output side: stall styles chosen at random, and one long hold-off on
    // request so that the block fills and stalls its input.
    initial begin : receiver
        int style;
        int style_left;
        bit hold_served;
        style       = 0;
        style_left  = 0;
        hold_served = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_served) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (style)
                0: out_ch.ready = 1'b1;
                1: out_ch.ready = ($urandom_range(0, 3) != 0);
                2: out_ch.ready = ($urandom_range(0, 3) == 0);
                default: out_ch.ready = ((style_left % 7) < 3);
            endcase
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int sent;
        int phase_len;
        int burst;
        bit no_gaps;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_req     = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.mode  = C_MODE_PIXEL;
        pix_ch.color = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset configuration: a one-pixel canvas at the origin. Only the
        // first row passes; a rewind with its color bits set brings it back.
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_item(C_MODE_REWIND, 16'hFFFF);
        send_pixel(16'hFFFF);

        // Negative lower corner, with corners given in reverse order: the
        // window starts at 0 although the draw area reaches below it.
        drain();
        write_corners(16'sd1, 16'sd0, -16'sd2, -16'sd1);
        write_reg(C_IDX_AREA_LEFT, -16'sd5);
        write_reg(C_IDX_AREA_TOP, -16'sd5);
        repeat (9) send_pixel(16'($urandom()));

        // Largest canvas and draw area.
        drain();
        write_corners(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        write_area(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        repeat (3) send_pixel(16'($urandom()));

        // Crossed window passes nothing; widening the area keeps the position.
        drain();
        write_corners(16'sd5, 16'sd5, 16'sd9, 16'sd9);
        write_area(16'sd8, 16'sd6, 16'sd0, 16'sd320);
        repeat (3) send_pixel(16'($urandom()));
        drain();
        write_reg(C_IDX_AREA_RIGHT, 16'sh7FFF);
        repeat (3) send_pixel(16'($urandom()));

        // Back-pressure: the receiver holds off while every pixel passes,
        // then the sender waits for every result.
        drain();
        write_corners(16'sd0, 16'sd0, 16'sd9, 16'sd9);
        write_area(16'sd0, C_AREA_RIGHT_RST, 16'sd0, C_AREA_BOTTOM_RST);
        hold_req = 1'b1;
        repeat (40) send_pixel(16'($urandom()));
        drain();

        // Random configurations, each followed by a random stream.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            if ($urandom_range(0, 3) != 0)
                write_corners(pick_coord(-8, 32), pick_coord(-8, 32),
                              pick_coord(-8, 32), pick_coord(-8, 32));
            write_area(pick_coord(-8, 20), pick_coord(0, 40),
                       pick_coord(-8, 20), pick_coord(0, 40));
            phase_len = $urandom_range(40, 200);
            no_gaps   = ($urandom_range(0, 3) == 0);
            while (phase_len > 0) begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && phase_len > 0) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(C_MODE_REWIND, 16'($urandom()));
                    else
                        send_pixel(16'($urandom()));
                    burst--;
                    phase_len--;
                    sent++;
                end
                if (!no_gaps) begin
                    pix_ch.valid = 1'b0;
                    repeat ($urandom_range(0, 6)) @(negedge clk);
                end
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
